/* rtl/core/tps_pkg.sv */
// Shared types and constants for the triangle plane splitter.
// Used by tps_front, tps_queue, tps_back and triangle_plane_splitter_top.
package tps_pkg;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [47:0] nrm;
		logic [47:0] tan;
		logic [47:0] bin;
		logic [31:0] u;
		logic [31:0] v;
	} vtx_t;

	// vertex codes in a side list: 0..2 triangle corners, then the two cuts
	typedef logic [2:0] vcode_t;
	localparam vcode_t VC_CUT0 = 3'd3;
	localparam vcode_t VC_CUT1 = 3'd4;

	// one classified triangle handed from front to back
	typedef struct packed {
		vtx_t [2:0]        v;
		logic [2:0][32:0]  d;
		vcode_t [3:0]      lst_l;
		logic [2:0]        n_l;
		vcode_t [3:0]      lst_r;
		logic [2:0]        n_r;
		logic [1:0][1:0]   cut_a;
		logic [1:0][1:0]   cut_b;
		logic [1:0]        n_cut;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SETUP,
		B_DIV,
		B_LERP,
		B_EMIT
	} bstate_t;

	localparam logic [0:0] REG_SPLIT_AXIS     = 1'b0;
	localparam logic [0:0] REG_SPLIT_POSITION = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;

	// interpolated components: 3 position, 9 vector, 2 texcoord
	localparam logic [3:0] NCOMP = 4'd14;

	function automatic logic [31:0] comp_get(vtx_t vt, logic [3:0] idx);
		logic [31:0] r;
		r = '0;
		case (idx)
			4'd0:  r = vt.x;
			4'd1:  r = vt.y;
			4'd2:  r = vt.z;
			4'd3:  r = {{16{vt.nrm[15]}}, vt.nrm[15:0]};
			4'd4:  r = {{16{vt.nrm[31]}}, vt.nrm[31:16]};
			4'd5:  r = {{16{vt.nrm[47]}}, vt.nrm[47:32]};
			4'd6:  r = {{16{vt.tan[15]}}, vt.tan[15:0]};
			4'd7:  r = {{16{vt.tan[31]}}, vt.tan[31:16]};
			4'd8:  r = {{16{vt.tan[47]}}, vt.tan[47:32]};
			4'd9:  r = {{16{vt.bin[15]}}, vt.bin[15:0]};
			4'd10: r = {{16{vt.bin[31]}}, vt.bin[31:16]};
			4'd11: r = {{16{vt.bin[47]}}, vt.bin[47:32]};
			4'd12: r = vt.u;
			4'd13: r = vt.v;
			default: r = '0;
		endcase
		return r;
	endfunction

	// quad order (0,1,2),(3,0,2)
	function automatic logic [1:0] quad_idx(logic [2:0] p);
		logic [1:0] r;
		r = 2'd0;
		case (p)
			3'd0: r = 2'd0;
			3'd1: r = 2'd1;
			3'd2: r = 2'd2;
			3'd3: r = 2'd3;
			3'd4: r = 2'd0;
			3'd5: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/triangle_plane_splitter_top.sv */
// Top level of the triangle plane splitter: front, queue and back.
// Depends on tps_pkg, tps_front, tps_queue, tps_back.

// Vertices arrive one beat at a time; every third beat closes a triangle, which is
// split against the plane at split_position on split_axis (3 acts as z). Left vertices
// (distance <= 0) come out first, then right, each side as a triangle or as the quad
// (0,1,2),(3,0,2); the last beat of a triangle has last_of_triangle set. The first two
// vertices of a triangle are taken one per cycle. The third is classified in the same
// cycle and placed in a two-entry queue. The back end fetches each triangle from the
// queue, then for each cut vertex runs a setup step, a bit-serial divider for the cut
// ratio and one shared multiplier for the 14 interpolated components, and then emits
// the output beats, holding them while out_stall is high.
module triangle_plane_splitter_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic [47:0]         normal_vec,
	input  logic [47:0]         tangent_vec,
	input  logic [47:0]         binormal_vec,
	input  logic signed [31:0]  tex_u,
	input  logic signed [31:0]  tex_v,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                side,
	output logic signed [31:0]  out_x,
	output logic signed [31:0]  out_y,
	output logic signed [31:0]  out_z,
	output logic [47:0]         out_normal,
	output logic [47:0]         out_tangent,
	output logic [47:0]         out_binormal,
	output logic signed [31:0]  out_u,
	output logic signed [31:0]  out_v,
	output logic                last_of_triangle,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import tps_pkg::*;

	job_t   wr_job, rd_job;
	qstat_t q_stat;
	logic   q_push, q_pop;

	tps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.normal_vec   (normal_vec),
		.tangent_vec  (tangent_vec),
		.binormal_vec (binormal_vec),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.qstat        (q_stat),
		.push         (q_push),
		.job          (wr_job)
	);

	tps_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (wr_job),
		.pop    (q_pop),
		.rd_job (rd_job),
		.qstat  (q_stat)
	);

	tps_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (rd_job),
		.qstat            (q_stat),
		.pop              (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.side             (side),
		.out_x            (out_x),
		.out_y            (out_y),
		.out_z            (out_z),
		.out_normal       (out_normal),
		.out_tangent      (out_tangent),
		.out_binormal     (out_binormal),
		.out_u            (out_u),
		.out_v            (out_v),
		.last_of_triangle (last_of_triangle)
	);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("triangle pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("triangle popped from empty queue");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("input stalled with room in queue");
`endif

endmodule

/* rtl/core/tps_front.sv */
// Front end: config registers, vertex holding, plane distances and side lists.
// Depends on tps_pkg; feeds tps_queue.
module tps_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic [47:0]          normal_vec,
	input  logic [47:0]          tangent_vec,
	input  logic [47:0]          binormal_vec,
	input  logic signed [31:0]   tex_u,
	input  logic signed [31:0]   tex_v,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  tps_pkg::qstat_t      qstat,
	output logic                 push,
	output tps_pkg::job_t        job
);
	import tps_pkg::*;

	logic [1:0]  axis_q;
	logic [31:0] splitpos_q;
	logic [1:0]  phase_q;
	vtx_t        v0_q, v1_q, vin;
	vtx_t [2:0]  vs;
	logic        acc;
	logic [2:0]  lft;
	logic [2:0][32:0] pdist;

	assign in_stall = (phase_q == 2'd2) & qstat.full;
	assign acc      = in_valid & ~in_stall;
	assign push     = acc & (phase_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q     <= '0;
			splitpos_q <= '0;
			phase_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SPLIT_AXIS) axis_q <= cfg_data[1:0];
				if (cfg_index == REG_SPLIT_POSITION) splitpos_q <= cfg_data;
			end
			if (acc) phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && phase_q == 2'd0) v0_q <= vin;
		if (acc && phase_q == 2'd1) v1_q <= vin;
	end

	always_comb begin
		vin.x   = pos_x;
		vin.y   = pos_y;
		vin.z   = pos_z;
		vin.nrm = normal_vec;
		vin.tan = tangent_vec;
		vin.bin = binormal_vec;
		vin.u   = tex_u;
		vin.v   = tex_v;
		vs[0]   = v0_q;
		vs[1]   = v1_q;
		vs[2]   = vin;
	end

	always_comb begin
		logic [31:0] p;
		for (int i = 0; i < 3; i++) begin
			if (axis_q == AXIS_X) p = vs[i].x;
			else if (axis_q == AXIS_Y) p = vs[i].y;
			else p = vs[i].z;
			pdist[i] = {p[31], p} - {splitpos_q[31], splitpos_q};
			lft[i]   = pdist[i][32] | (pdist[i] == '0);
		end
	end

	// walk edges 0->1, 1->2, 2->0; cut vertices go to both sides
	always_comb begin
		logic [2:0] nl, nr;
		logic [1:0] nc;
		int         nx;
		nl = '0;
		nr = '0;
		nc = '0;
		job.v     = vs;
		job.d     = pdist;
		job.lst_l = '0;
		job.lst_r = '0;
		job.cut_a = '0;
		job.cut_b = '0;
		for (int i = 0; i < 3; i++) begin
			nx = (i == 2) ? 0 : i + 1;
			if (lft[i]) begin
				job.lst_l[nl[1:0]] = vcode_t'(i);
				nl = nl + 3'd1;
			end else begin
				job.lst_r[nr[1:0]] = vcode_t'(i);
				nr = nr + 3'd1;
			end
			if (lft[i] != lft[nx]) begin
				job.cut_a[nc[0]] = 2'(i);
				job.cut_b[nc[0]] = 2'(nx);
				job.lst_l[nl[1:0]] = (nc == 2'd0) ? VC_CUT0 : VC_CUT1;
				job.lst_r[nr[1:0]] = (nc == 2'd0) ? VC_CUT0 : VC_CUT1;
				nl = nl + 3'd1;
				nr = nr + 3'd1;
				nc = nc + 2'd1;
			end
		end
		job.n_l   = nl;
		job.n_r   = nr;
		job.n_cut = nc;
	end

endmodule

/* rtl/core/tps_queue.sv */
// Two-entry queue of classified triangles between front and back.
// Depends on tps_pkg.
module tps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tps_pkg::job_t   wr_job,
	input  logic            pop,
	output tps_pkg::job_t   rd_job,
	output tps_pkg::qstat_t qstat
);
	import tps_pkg::*;

	job_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign rd_job      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_job;
	end

endmodule

/* rtl/core/tps_back.sv */
// Back end: per-cut divider and shared interpolator, then vertex emission.
// Depends on tps_pkg; reads triangles from tps_queue.
module tps_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tps_pkg::job_t       head,
	input  tps_pkg::qstat_t     qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                side,
	output logic signed [31:0]  out_x,
	output logic signed [31:0]  out_y,
	output logic signed [31:0]  out_z,
	output logic [47:0]         out_normal,
	output logic [47:0]         out_tangent,
	output logic [47:0]         out_binormal,
	output logic signed [31:0]  out_u,
	output logic signed [31:0]  out_v,
	output logic                last_of_triangle
);
	import tps_pkg::*;

	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam int PW = 33 + FRAC_BITS + 2;

	bstate_t st_q, st_d;
	job_t    job_q;
	logic    ci_q;
	logic [CW-1:0]      dcnt_q;
	logic [34:0]        rem_q;
	logic [33:0]        den_q;
	logic [FRAC_BITS:0] k_q;
	logic [3:0]         lidx_q;
	logic signed [PW-1:0] prod_s1;
	logic [31:0]        c0_s1;
	logic [3:0]         widx_s1;
	logic               wv_s1;
	logic [31:0]        cut_c_q [2][14];
	logic               eside_q;
	logic [2:0]         ep_q;
	logic               out_valid_q;

	vtx_t        va, vb, ev;
	vtx_t [1:0]  cutv;
	logic [32:0] da, db;
	logic [33:0] ad, dd, add;
	logic [34:0] t;
	logic        ge;
	logic [31:0] c0, c1;
	logic signed [32:0] diff;
	logic [2:0]  n_sel;
	vcode_t      code;
	logic        side_last, all_last, load, issue;

	assign out_valid = out_valid_q;
	assign load      = (st_q == B_EMIT) & (~out_valid_q | ~out_stall);
	assign issue     = (st_q == B_LERP) & (lidx_q < NCOMP);

	// divider and interpolator operands for the current cut
	always_comb begin
		va  = job_q.v[job_q.cut_a[ci_q]];
		vb  = job_q.v[job_q.cut_b[ci_q]];
		da  = job_q.d[job_q.cut_a[ci_q]];
		db  = job_q.d[job_q.cut_b[ci_q]];
		ad  = da[32] ? -{da[32], da} : {da[32], da};
		dd  = {db[32], db} - {da[32], da};
		add = dd[33] ? -dd : dd;
		t   = (dcnt_q == '0) ? rem_q : {rem_q[33:0], 1'b0};
		ge  = (t >= {1'b0, den_q});
		c0   = comp_get(va, lidx_q);
		c1   = comp_get(vb, lidx_q);
		diff = $signed({c1[31], c1}) - $signed({c0[31], c0});
	end

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			cutv[j].x   = cut_c_q[j][0];
			cutv[j].y   = cut_c_q[j][1];
			cutv[j].z   = cut_c_q[j][2];
			cutv[j].nrm = {cut_c_q[j][5][15:0], cut_c_q[j][4][15:0], cut_c_q[j][3][15:0]};
			cutv[j].tan = {cut_c_q[j][8][15:0], cut_c_q[j][7][15:0], cut_c_q[j][6][15:0]};
			cutv[j].bin = {cut_c_q[j][11][15:0], cut_c_q[j][10][15:0], cut_c_q[j][9][15:0]};
			cutv[j].u   = cut_c_q[j][12];
			cutv[j].v   = cut_c_q[j][13];
		end
	end

	// emission selection
	always_comb begin
		n_sel = eside_q ? job_q.n_r : job_q.n_l;
		code  = eside_q ? job_q.lst_r[quad_idx(ep_q)] : job_q.lst_l[quad_idx(ep_q)];
		case (code)
			VC_CUT0: ev = cutv[0];
			VC_CUT1: ev = cutv[1];
			default: ev = job_q.v[code[1:0]];
		endcase
		side_last = (n_sel == 3'd3) ? (ep_q == 3'd2) : (ep_q == 3'd5);
		all_last  = side_last & (eside_q | (job_q.n_r == 3'd0));
	end

	always_comb begin
		st_d = st_q;
		pop  = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					pop  = 1'b1;
					st_d = (head.n_cut != 2'd0) ? B_SETUP : B_EMIT;
				end
			end
			B_SETUP: st_d = B_DIV;
			B_DIV: begin
				if (dcnt_q == CW'(FRAC_BITS)) st_d = B_LERP;
			end
			B_LERP: begin
				if (lidx_q == NCOMP)
					st_d = (!ci_q && job_q.n_cut == 2'd2) ? B_SETUP : B_EMIT;
			end
			B_EMIT: begin
				if (load && all_last) st_d = B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			ci_q        <= 1'b0;
			dcnt_q      <= '0;
			lidx_q      <= '0;
			eside_q     <= 1'b0;
			ep_q        <= '0;
			wv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			wv_s1 <= issue;
			case (st_q)
				B_IDLE: begin
					ci_q    <= 1'b0;
					eside_q <= (head.n_l == 3'd0);
					ep_q    <= '0;
				end
				B_SETUP: dcnt_q <= '0;
				B_DIV: begin
					dcnt_q <= dcnt_q + CW'(1);
					lidx_q <= '0;
				end
				B_LERP: begin
					if (issue) lidx_q <= lidx_q + 4'd1;
					else ci_q <= 1'b1;
				end
				B_EMIT: begin
					if (load) begin
						if (side_last) begin
							eside_q <= 1'b1;
							ep_q    <= '0;
						end else begin
							ep_q <= ep_q + 3'd1;
						end
					end
				end
				default: ;
			endcase
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == B_IDLE && !qstat.empty) job_q <= head;
		if (st_q == B_SETUP) begin
			rem_q <= {1'b0, ad};
			den_q <= add;
		end
		if (st_q == B_DIV) begin
			rem_q <= ge ? t - {1'b0, den_q} : t;
			k_q   <= {k_q[FRAC_BITS-1:0], ge};
		end
		if (issue) begin
			prod_s1 <= PW'(diff * $signed({1'b0, k_q}));
			c0_s1   <= c0;
			widx_s1 <= lidx_q;
		end
		// floor((c0*(1-k) + c1*k) / 2^F) == c0 + floor((c1-c0)*k / 2^F)
		if (wv_s1) cut_c_q[ci_q][widx_s1] <= c0_s1 + prod_s1[FRAC_BITS +: 32];
		if (load) begin
			side             <= eside_q;
			out_x            <= ev.x;
			out_y            <= ev.y;
			out_z            <= ev.z;
			out_normal       <= ev.nrm;
			out_tangent      <= ev.tan;
			out_binormal     <= ev.bin;
			out_u            <= ev.u;
			out_v            <= ev.v;
			last_of_triangle <= all_last;
		end
	end

endmodule
